>>> rtl/window_layer_compositor_macros.svh
// Concurrent assertion helpers shared by the compositor modules.
`ifndef WINDOW_LAYER_COMPOSITOR_MACROS_SVH
`define WINDOW_LAYER_COMPOSITOR_MACROS_SVH

`ifndef SYNTHESIS
`define WLC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wlc assertion failed");
`define WLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wlc assertion failed");
`else
`define WLC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define WLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/wlc_pkg.sv
`timescale 1ns / 1ps
package wlc_pkg;

	localparam int MAX_LAYERS_DEF  = 16;
	localparam int CURSOR_EDGE_DEF = 16;

	localparam int COORD_W = 12;
	localparam int SIZE_W  = 11;
	localparam int COLOR_W = 32;
	localparam int FW_W    = 11;
	localparam int FH_W    = 10;
	localparam int SLOT_W  = 4;
	localparam int STAT_W  = 2;
	localparam int CIDX_W  = 2;

	localparam logic [FW_W-1:0]    FRAME_W_RST      = FW_W'(1024);
	localparam logic [FH_W-1:0]    FRAME_H_RST      = FH_W'(768);
	localparam logic [COLOR_W-1:0] BG_COLOR_RST     = '0;
	localparam logic [COLOR_W-1:0] CURSOR_COLOR_RST = COLOR_W'(32'h0000_00FF);
	localparam logic [COORD_W-1:0] CURSOR_X_RST     = COORD_W'(1024 / 2);
	localparam logic [COORD_W-1:0] CURSOR_Y_RST     = COORD_W'(768 / 2);

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OUTSIDE = 2'd2;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_MOUSE = 2'd1,
		OP_QUERY = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_FRAME_W      = 2'd0,
		CFG_FRAME_H      = 2'd1,
		CFG_BG_COLOR     = 2'd2,
		CFG_CURSOR_COLOR = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_EXEC,
		CS_READ,
		CS_TEST,
		CS_MOVE,
		CS_DONE
	} ctl_state_t;

	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [SIZE_W-1:0]  width;
		logic [SIZE_W-1:0]  height;
		logic [COLOR_W-1:0] color;
	} rect_t;

	typedef struct packed {
		logic capture;
		logic prep;
		logic append;
		logic set_cursor;
		logic release_grab;
		logic read_grab;
		logic move_write;
		logic scan_init;
		logic scan_dec;
		logic grab_take;
		logic color_take;
		logic emit;
	} wlc_cmd_t;

	typedef struct packed {
		op_t  op;
		logic full;
		logic button;
		logic grab;
		logic frame_out;
		logic cursor_hit;
		logic empty;
		logic hit;
		logic scan_last;
		logic out_busy;
	} wlc_stat_t;

	// Half-open containment test on 14-bit signed coordinates.
	function automatic logic rect_covers(rect_t r, logic [COORD_W-1:0] px,
			logic [COORD_W-1:0] py);
		logic signed [13:0] l;
		logic signed [13:0] t;
		logic signed [13:0] x;
		logic signed [13:0] y;
		logic signed [13:0] rgt;
		logic signed [13:0] bot;
		l   = $signed({{2{r.left[COORD_W-1]}}, r.left});
		t   = $signed({{2{r.top[COORD_W-1]}}, r.top});
		x   = $signed({{2{px[COORD_W-1]}}, px});
		y   = $signed({{2{py[COORD_W-1]}}, py});
		rgt = l + $signed({3'b000, r.width});
		bot = t + $signed({3'b000, r.height});
		return (x >= l) && (x < rgt) && (y >= t) && (y < bot);
	endfunction

endpackage

>>> rtl/window_layer_compositor.sv
`timescale 1ns / 1ps
// Layer compositor: a table of up to MAX_LAYERS solid rectangles, a square
// cursor of CURSOR_EDGE pixels and a mouse drag grab. op 0 appends a
// rectangle, op 1 moves the cursor and grabs, drags or releases, op 2
// returns one pixel's color; each input transaction yields one result
// transaction. Items run one at a time through a controller that walks the
// rectangle memory, one read per entry. Add, no-op, release, off-frame and
// cursor-covered queries skip the walk, a drag reads and rewrites the grabbed
// rectangle, and a grab search or rectangle query examines rectangles from
// the top down until one covers the point (at most the number stored). A
// finished result waits in an output register while the next item is
// accepted. Configuration writes are always ready and take effect on the
// next cycle.
module window_layer_compositor
	import wlc_pkg::*;
#(
	parameter int MAX_LAYERS  = MAX_LAYERS_DEF,
	parameter int CURSOR_EDGE = CURSOR_EDGE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic [COORD_W-1:0] pos_x,
	input  logic [COORD_W-1:0] pos_y,
	input  logic [SIZE_W-1:0]  size_w,
	input  logic [SIZE_W-1:0]  size_h,
	input  logic [COLOR_W-1:0] color_in,
	input  logic               button,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [COLOR_W-1:0] pixel_color,
	output logic [STAT_W-1:0]  status,
	output logic               grab_held,
	output logic [SLOT_W-1:0]  grab_slot,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [COLOR_W-1:0] cfg_data
);

	wlc_cmd_t  cmd;
	wlc_stat_t stat;

	assign cfg_ready = 1'b1;

	wlc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	wlc_datapath #(
		.MAX_LAYERS  (MAX_LAYERS),
		.CURSOR_EDGE (CURSOR_EDGE)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.op          (op),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.size_w      (size_w),
		.size_h      (size_h),
		.color_in    (color_in),
		.button      (button),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_color (pixel_color),
		.status      (status),
		.grab_held   (grab_held),
		.grab_slot   (grab_slot)
	);

endmodule

>>> rtl/wlc_ctrl.sv
`timescale 1ns / 1ps
`include "window_layer_compositor_macros.svh"
module wlc_ctrl
	import wlc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  wlc_stat_t stat,
	output wlc_cmd_t  cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			CS_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = CS_EXEC;
				end
			end
			CS_EXEC: begin
				cmd.prep = 1'b1;
				state_d  = CS_DONE;
				unique case (stat.op)
					OP_ADD: begin
						cmd.append = !stat.full;
					end
					OP_MOUSE: begin
						cmd.set_cursor = 1'b1;
						if (!stat.button) begin
							cmd.release_grab = 1'b1;
						end else if (stat.grab) begin
							cmd.read_grab = 1'b1;
							state_d       = CS_MOVE;
						end else if (!stat.empty) begin
							cmd.scan_init = 1'b1;
							state_d       = CS_READ;
						end
					end
					OP_QUERY: begin
						if (!stat.frame_out && !stat.cursor_hit && !stat.empty) begin
							cmd.scan_init = 1'b1;
							state_d       = CS_READ;
						end
					end
					default: begin
					end
				endcase
			end
			CS_READ: begin
				state_d = CS_TEST;
			end
			CS_TEST: begin
				if (stat.hit) begin
					cmd.grab_take  = (stat.op == OP_MOUSE);
					cmd.color_take = (stat.op == OP_QUERY);
					state_d        = CS_DONE;
				end else if (stat.scan_last) begin
					state_d = CS_DONE;
				end else begin
					cmd.scan_dec = 1'b1;
					state_d      = CS_READ;
				end
			end
			CS_MOVE: begin
				cmd.move_write = 1'b1;
				state_d        = CS_DONE;
			end
			CS_DONE: begin
				// hold until the output register is free
				if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	`WLC_ASSERT_NEXT(a_accept_exec, clk, arst_n, in_valid && !in_stall, state_q == CS_EXEC)
	`WLC_ASSERT_NEXT(a_hit_done, clk, arst_n, state_q == CS_TEST && stat.hit, state_q == CS_DONE)

endmodule

>>> rtl/wlc_datapath.sv
`timescale 1ns / 1ps
`include "window_layer_compositor_macros.svh"
module wlc_datapath
	import wlc_pkg::*;
#(
	parameter int MAX_LAYERS  = MAX_LAYERS_DEF,
	parameter int CURSOR_EDGE = CURSOR_EDGE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wlc_cmd_t           cmd,
	output wlc_stat_t          stat,
	input  logic               cfg_we,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [COLOR_W-1:0] cfg_data,
	input  logic [1:0]         op,
	input  logic [COORD_W-1:0] pos_x,
	input  logic [COORD_W-1:0] pos_y,
	input  logic [SIZE_W-1:0]  size_w,
	input  logic [SIZE_W-1:0]  size_h,
	input  logic [COLOR_W-1:0] color_in,
	input  logic               button,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [COLOR_W-1:0] pixel_color,
	output logic [STAT_W-1:0]  status,
	output logic               grab_held,
	output logic [SLOT_W-1:0]  grab_slot
);

	localparam int CNT_W = $clog2(MAX_LAYERS + 1);
	localparam int IDX_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
	localparam logic signed [13:0] EDGE = 14'(CURSOR_EDGE);

	logic [FW_W-1:0]    frame_w_q;
	logic [FH_W-1:0]    frame_h_q;
	logic [COLOR_W-1:0] bg_color_q;
	logic [COLOR_W-1:0] cursor_color_q;

	op_t                op_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [SIZE_W-1:0]  w_q;
	logic [SIZE_W-1:0]  h_q;
	logic [COLOR_W-1:0] color_q;
	logic               button_q;

	logic [CNT_W-1:0]   cnt_q;
	logic [COORD_W-1:0] cur_x_q;
	logic [COORD_W-1:0] cur_y_q;
	logic               grab_active_q;
	logic [IDX_W-1:0]   grab_idx_q;
	logic [COORD_W-1:0] off_x_q;
	logic [COORD_W-1:0] off_y_q;
	logic [IDX_W-1:0]   scan_idx_q;

	logic [COLOR_W-1:0] res_color_q;
	logic [STAT_W-1:0]  res_status_q;

	logic               out_valid_q;
	logic [COLOR_W-1:0] out_color_q;
	logic [STAT_W-1:0]  out_status_q;
	logic               out_held_q;
	logic [SLOT_W-1:0]  out_slot_q;

	rect_t              rect_mem_q [MAX_LAYERS];
	rect_t              rd_data_q;
	rect_t              wr_data;
	rect_t              moved;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [IDX_W-1:0]   rd_addr;

	logic               frame_out;
	logic               cursor_hit;
	logic signed [13:0] px;
	logic signed [13:0] py;
	logic signed [13:0] cx;
	logic signed [13:0] cy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q      <= FRAME_W_RST;
			frame_h_q      <= FRAME_H_RST;
			bg_color_q     <= BG_COLOR_RST;
			cursor_color_q <= CURSOR_COLOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FRAME_W:      frame_w_q      <= cfg_data[FW_W-1:0];
				CFG_FRAME_H:      frame_h_q      <= cfg_data[FH_W-1:0];
				CFG_BG_COLOR:     bg_color_q     <= cfg_data;
				CFG_CURSOR_COLOR: cursor_color_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= op_t'(op);
			x_q      <= pos_x;
			y_q      <= pos_y;
			w_q      <= size_w;
			h_q      <= size_h;
			color_q  <= color_in;
			button_q <= button;
		end
	end

	assign px = $signed({{2{x_q[COORD_W-1]}}, x_q});
	assign py = $signed({{2{y_q[COORD_W-1]}}, y_q});
	assign cx = $signed({{2{cur_x_q[COORD_W-1]}}, cur_x_q});
	assign cy = $signed({{2{cur_y_q[COORD_W-1]}}, cur_y_q});

	// A non-negative 12-bit coordinate fits in its low 11 bits.
	assign frame_out = x_q[COORD_W-1] || y_q[COORD_W-1] ||
		(x_q[FW_W-1:0] >= frame_w_q) || (y_q[SIZE_W-1:0] >= {1'b0, frame_h_q});
	assign cursor_hit = (px >= cx) && (px < cx + EDGE) && (py >= cy) && (py < cy + EDGE);

	always_comb begin
		moved      = rd_data_q;
		moved.left = x_q - off_x_q;
		moved.top  = y_q - off_y_q;
	end

	assign wr_en   = cmd.append || cmd.move_write;
	assign wr_addr = cmd.append ? cnt_q[IDX_W-1:0] : grab_idx_q;
	assign wr_data = cmd.append ? rect_t'({x_q, y_q, w_q, h_q, color_q}) : moved;
	assign rd_addr = cmd.read_grab ? grab_idx_q : scan_idx_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rect_mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= rect_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			cur_x_q       <= CURSOR_X_RST;
			cur_y_q       <= CURSOR_Y_RST;
			grab_active_q <= 1'b0;
			grab_idx_q    <= '0;
			off_x_q       <= '0;
			off_y_q       <= '0;
			scan_idx_q    <= '0;
		end else begin
			if (cmd.append) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.set_cursor) begin
				cur_x_q <= x_q;
				cur_y_q <= y_q;
			end
			if (cmd.release_grab) begin
				grab_active_q <= 1'b0;
			end else if (cmd.grab_take) begin
				grab_active_q <= 1'b1;
				grab_idx_q    <= scan_idx_q;
				off_x_q       <= x_q - rd_data_q.left;
				off_y_q       <= y_q - rd_data_q.top;
			end
			// scan from the topmost rectangle down
			if (cmd.scan_init) begin
				scan_idx_q <= IDX_W'(cnt_q - CNT_W'(1));
			end else if (cmd.scan_dec) begin
				scan_idx_q <= scan_idx_q - IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			if (op_q == OP_ADD && stat.full) begin
				res_status_q <= STAT_FULL;
			end else if (op_q == OP_QUERY && frame_out) begin
				res_status_q <= STAT_OUTSIDE;
			end else begin
				res_status_q <= STAT_OK;
			end
			if (op_q == OP_QUERY && !frame_out) begin
				res_color_q <= cursor_hit ? cursor_color_q : bg_color_q;
			end else begin
				res_color_q <= '0;
			end
		end else if (cmd.color_take) begin
			res_color_q <= rd_data_q.color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_color_q  <= res_color_q;
			out_status_q <= res_status_q;
			out_held_q   <= grab_active_q;
			out_slot_q   <= grab_active_q ? SLOT_W'(grab_idx_q) : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_color = out_color_q;
	assign status      = out_status_q;
	assign grab_held   = out_held_q;
	assign grab_slot   = out_slot_q;

	always_comb begin
		stat            = '0;
		stat.op         = op_q;
		stat.full       = (cnt_q == CNT_W'(MAX_LAYERS));
		stat.button     = button_q;
		stat.grab       = grab_active_q;
		stat.frame_out  = frame_out;
		stat.cursor_hit = cursor_hit;
		stat.empty      = (cnt_q == '0);
		stat.hit        = rect_covers(rd_data_q, x_q, y_q);
		stat.scan_last  = (scan_idx_q == '0);
		stat.out_busy   = out_valid_q && out_stall;
	end

	`WLC_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(MAX_LAYERS))
	`WLC_ASSERT_IMPL(a_grab_in_table, clk, arst_n, grab_active_q, CNT_W'(grab_idx_q) < cnt_q)

endmodule
